FILE: src/npss_pkg.sv
// Shared constants and types for the nearest point snap selector.
package npss_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAY_MODE      = 3'd0,
    CFG_QUERY_ORIGIN  = 3'd1,
    CFG_RAY_DIRECTION = 3'd2,
    CFG_CONE_COSINE   = 3'd3,
    CFG_PICK_RADIUS   = 3'd4
  } cfg_idx_t;

  // Register widths and reset values.
  localparam int ORIGIN_W = 48;
  localparam int DIR_W    = 48;
  localparam int DIR_CW   = 16;
  localparam int COS_W    = 15;
  localparam int RAD_W    = 16;

  localparam logic [COS_W-1:0] COS_RESET = 15'd16000;
  localparam logic [RAD_W-1:0] RAD_RESET = 16'd256;

  // Item operation codes.
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: src/npss_front.sv
// Front part: accept items, form point offsets from the query origin.
module npss_front
  import npss_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic signed [CW-1:0]        in_point_x,
  input  logic signed [CW-1:0]        in_point_y,
  input  logic signed [CW-1:0]        in_point_z,
  input  logic [ORIGIN_W-1:0]         query_origin,
  input  q_stat_t                     q_stat,
  output logic                        push,
  output logic [1+3*CW+3*(CW+1)-1:0]  push_data
);

  localparam int IW = 1 + 3*CW + 3*(CW+1);
  localparam int OW = (3*CW > ORIGIN_W) ? 3*CW : ORIGIN_W;

  logic                 valid_r, valid_nxt;
  logic [IW-1:0]        item_r, item_nxt;
  logic [OW-1:0]        org_pad;
  logic                 accept;
  logic signed [CW-1:0] pt [3];
  logic signed [CW-1:0] org [3];
  logic signed [CW:0]   po [3];

  assign org_pad  = OW'(query_origin);
  assign pt[0]    = in_point_x;
  assign pt[1]    = in_point_y;
  assign pt[2]    = in_point_z;

  assign push     = valid_r && !q_stat.full;
  assign in_stall = valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push_data = item_r;

  always_comb begin
    item_nxt = item_r;
    for (int i = 0; i < 3; i++) begin
      org[i] = $signed(org_pad[CW*i +: CW]);
      po[i]  = $signed({pt[i][CW-1], pt[i]}) - $signed({org[i][CW-1], org[i]});
    end
    if (accept) begin
      item_nxt[IW-1] = in_operation;
      for (int i = 0; i < 3; i++) begin
        item_nxt[3*(CW+1) + CW*i +: CW] = pt[i];
        item_nxt[(CW+1)*i +: CW+1]      = po[i];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

FILE: src/npss_queue.sv
// Two-entry queue between the front and back parts.
module npss_queue
  import npss_pkg::*;
#(
  parameter int WIDTH = 100
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          q_stat
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign q_stat.full  = (count_r == (PTR_W+1)'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_data     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/npss_back.sv
// Back part: distance and cone tests, best-target state and result register.
module npss_back
  import npss_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  q_stat_t                     q_stat,
  output logic                        pop,
  input  logic [1+3*CW+3*(CW+1)-1:0]  pop_data,
  input  logic                        ray_mode,
  input  logic [DIR_W-1:0]            ray_direction,
  input  logic [COS_W-1:0]            cone_cosine,
  input  logic [RAD_W-1:0]            pick_radius,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_accepted,
  output logic                        out_snapped,
  output logic signed [CW-1:0]        out_snap_x,
  output logic signed [CW-1:0]        out_snap_y,
  output logic signed [CW-1:0]        out_snap_z
);

  localparam int IW    = 1 + 3*CW + 3*(CW+1);
  localparam int LW    = 2*CW + 2;           // squared distance / limit
  localparam int SQ_W  = 2*CW + 1;           // one squared offset
  localparam int PR_W  = CW + 1 + DIR_CW;    // one dot product term
  localparam int DOT_W = PR_W + 2;           // dot product
  localparam int DM_W  = DOT_W - 1;          // magnitude of a positive dot
  localparam int DL_W  = DM_W / 2;
  localparam int DH_W  = DM_W - DL_W;
  localparam int C2_W  = 2*COS_W;
  localparam int LL_W  = LW / 2;
  localparam int LH_W  = LW - LL_W;
  localparam int PW    = 2*DM_W;             // both sides of the cone test
  localparam int R2_W  = 2*RAD_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_PART = 6'b001000,
    ST_ADD  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Item under work.
  logic                 op_r;
  logic signed [CW-1:0] pt_r [3];
  logic signed [CW:0]   po_r [3];

  // Datapath pipeline.
  logic [SQ_W-1:0]        sq_r [3];
  logic signed [PR_W-1:0] pr_r [3];
  logic [C2_W-1:0]        c2_r;
  logic [LW-1:0]          d2_r;
  logic signed [DOT_W-1:0] dot_r;
  logic                   lt_r;
  logic                   dpos_r;
  logic [2*DH_W-1:0]      hh_r;
  logic [DH_W+DL_W-1:0]   hl_r;
  logic [2*DL_W-1:0]      ll_r;
  logic [C2_W+LL_W-1:0]   clo_r;
  logic [C2_W+LH_W-1:0]   chi_r;
  logic [PW-1:0]          dot2_r;
  logic [PW-1:0]          cd2_r;

  // Selection state.
  logic [LW-1:0]        limit_r, limit_nxt;
  logic                 snapped_r, snapped_nxt;
  logic signed [CW-1:0] snap_r [3];
  logic signed [CW-1:0] snap_nxt [3];

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_acc_r, out_acc_nxt;
  logic                 out_snapped_r, out_snapped_nxt;
  logic signed [CW-1:0] out_snap_r [3];
  logic signed [CW-1:0] out_snap_nxt [3];

  logic                   out_free;
  logic                   fin_fire;
  logic                   take;
  logic [R2_W-1:0]        r2;
  logic [LW-1:0]          r2_lim;
  logic signed [DIR_CW-1:0] dir [3];
  logic [DM_W-1:0]        dm;

  assign out_free = !out_valid_r || !out_stall;
  assign fin_fire = (state_r == ST_FIN) && out_free;
  assign pop      = (state_r == ST_IDLE) && !q_stat.empty;

  assign dir[0] = $signed(ray_direction[DIR_CW*0 +: DIR_CW]);
  assign dir[1] = $signed(ray_direction[DIR_CW*1 +: DIR_CW]);
  assign dir[2] = $signed(ray_direction[DIR_CW*2 +: DIR_CW]);
  assign dm     = dot_r[DM_W-1:0];

  // Saturate the radius squared into the limit width.
  assign r2     = pick_radius * pick_radius;
  assign r2_lim = ((r2 >> LW) != '0) ? '1 : LW'(r2);

  assign take = (op_r == OP_TEST) && lt_r &&
                (!ray_mode || (dpos_r && (dot2_r > cd2_r)));

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = (pop_data[IW-1] == OP_BEGIN) ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_PART;
      ST_PART: state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Selection update and result.
  always_comb begin
    limit_nxt   = limit_r;
    snapped_nxt = snapped_r;
    snap_nxt    = snap_r;
    out_acc_nxt     = out_acc_r;
    out_snapped_nxt = out_snapped_r;
    out_snap_nxt    = out_snap_r;
    out_valid_nxt   = out_stall ? out_valid_r : 1'b0;
    if (fin_fire) begin
      if (op_r == OP_BEGIN) begin
        snapped_nxt = 1'b0;
        limit_nxt   = ray_mode ? '1 : r2_lim;
      end else if (take) begin
        snapped_nxt = 1'b1;
        limit_nxt   = d2_r;
        snap_nxt    = pt_r;
      end
      out_valid_nxt   = 1'b1;
      out_acc_nxt     = take;
      out_snapped_nxt = snapped_nxt;
      for (int i = 0; i < 3; i++) begin
        out_snap_nxt[i] = snapped_nxt ? snap_nxt[i] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= '1;
      snapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        snap_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      snapped_r   <= snapped_nxt;
      out_valid_r <= out_valid_nxt;
      snap_r      <= snap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_acc_r     <= out_acc_nxt;
    out_snapped_r <= out_snapped_nxt;
    out_snap_r    <= out_snap_nxt;
  end

  // Load the item on pop; hold it until the next pop.
  always_ff @(posedge clk) begin
    if (pop) begin
      op_r <= pop_data[IW-1];
      for (int i = 0; i < 3; i++) begin
        pt_r[i] <= $signed(pop_data[3*(CW+1) + CW*i +: CW]);
        po_r[i] <= $signed(pop_data[(CW+1)*i +: CW+1]);
      end
    end
  end

  // Arithmetic stages advance every cycle; the sequencer samples them in turn.
  always_ff @(posedge clk) begin
    // ST_MUL: squares and dot product terms
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= SQ_W'(po_r[i] * po_r[i]);
      pr_r[i] <= po_r[i] * dir[i];
    end
    c2_r <= cone_cosine * cone_cosine;
    // ST_SUM: reduce
    d2_r  <= LW'(sq_r[0]) + LW'(sq_r[1]) + LW'(sq_r[2]);
    dot_r <= DOT_W'(pr_r[0]) + DOT_W'(pr_r[1]) + DOT_W'(pr_r[2]);
    // ST_PART: limit compare and split products
    lt_r   <= d2_r < limit_r;
    dpos_r <= !dot_r[DOT_W-1] && (dot_r != '0);
    hh_r   <= dm[DM_W-1:DL_W] * dm[DM_W-1:DL_W];
    hl_r   <= dm[DM_W-1:DL_W] * dm[DL_W-1:0];
    ll_r   <= dm[DL_W-1:0] * dm[DL_W-1:0];
    clo_r  <= c2_r * d2_r[LL_W-1:0];
    chi_r  <= c2_r * d2_r[LW-1:LL_W];
    // ST_ADD: assemble both sides of the cone test
    dot2_r <= (PW'(hh_r) << (2*DL_W)) + (PW'(hl_r) << (DL_W+1)) + PW'(ll_r);
    cd2_r  <= (PW'(chi_r) << LL_W) + PW'(clo_r);
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_snapped  = out_snapped_r;
  assign out_snap_x   = out_snap_r[0];
  assign out_snap_y   = out_snap_r[1];
  assign out_snap_z   = out_snap_r[2];

endmodule

FILE: src/nearest_point_snap_selector.sv
// Top level of the nearest point snap selector: configuration registers and parts.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------
//  in_     | input     | in_valid / in_stall   | operation, point_x, point_y, point_z
//  out_    | output    | out_valid / out_stall | accepted, snapped, snap_x/y/z
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// In the back part a begin transaction goes from the pop to the select step; a test
// transaction goes from the pop through squares and dot terms, sums, split products,
// assembly, and the select step. The back sequencer works on one transaction at a
// time; the front register and a two-entry queue keep taking input meanwhile.
// Reset (rst_n low, synchronous) empties the front and queue, clears the result
// valid flag, loads the limit with all ones and clears the snap point and flag.
// Stalls: in_stall rises only when the front register and queue are full;
// out_stall holds the result register and the back waits in its select step.
module nearest_point_snap_selector
  import npss_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_accepted,
  output logic                         out_snapped,
  output logic signed [COORD_WIDTH-1:0] out_snap_x,
  output logic signed [COORD_WIDTH-1:0] out_snap_y,
  output logic signed [COORD_WIDTH-1:0] out_snap_z,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  // Queue item: operation, three points and three offsets from the origin.
  localparam int IW = 1 + 3*COORD_WIDTH + 3*(COORD_WIDTH+1);

  // Configuration registers.
  logic                ray_mode_r, ray_mode_nxt;
  logic [ORIGIN_W-1:0] origin_r, origin_nxt;
  logic [DIR_W-1:0]    dir_r, dir_nxt;
  logic [COS_W-1:0]    cos_r, cos_nxt;
  logic [RAD_W-1:0]    radius_r, radius_nxt;

  q_stat_t         q_stat;
  logic            push;
  logic            pop;
  logic [IW-1:0]   push_data;
  logic [IW-1:0]   pop_data;

  // Decode the register write; unknown indexes are dropped.
  always_comb begin
    ray_mode_nxt = ray_mode_r;
    origin_nxt   = origin_r;
    dir_nxt      = dir_r;
    cos_nxt      = cos_r;
    radius_nxt   = radius_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RAY_MODE:      ray_mode_nxt = cfg_wdata[0];
        CFG_QUERY_ORIGIN:  origin_nxt   = cfg_wdata[ORIGIN_W-1:0];
        CFG_RAY_DIRECTION: dir_nxt      = cfg_wdata[DIR_W-1:0];
        CFG_CONE_COSINE:   cos_nxt      = cfg_wdata[COS_W-1:0];
        CFG_PICK_RADIUS:   radius_nxt   = cfg_wdata[RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_mode_r <= 1'b0;
      origin_r   <= '0;
      dir_r      <= '0;
      cos_r      <= COS_RESET;
      radius_r   <= RAD_RESET;
    end else begin
      ray_mode_r <= ray_mode_nxt;
      origin_r   <= origin_nxt;
      dir_r      <= dir_nxt;
      cos_r      <= cos_nxt;
      radius_r   <= radius_nxt;
    end
  end

  // Front: take transactions and form offsets from the query origin.
  npss_front #(
    .CW (COORD_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_point_z   (in_point_z),
    .query_origin (origin_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  // Queue: decouple front acceptance from the back sequencer.
  npss_queue #(
    .WIDTH (IW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // Back: run the distance and cone tests, update the best target, present results.
  npss_back #(
    .CW (COORD_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .pop           (pop),
    .pop_data      (pop_data),
    .ray_mode      (ray_mode_r),
    .ray_direction (dir_r),
    .cone_cosine   (cos_r),
    .pick_radius   (radius_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_accepted  (out_accepted),
    .out_snapped   (out_snapped),
    .out_snap_x    (out_snap_x),
    .out_snap_y    (out_snap_y),
    .out_snap_z    (out_snap_z)
  );

endmodule
